// ----- design/klc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the keyboard link controller.
// No dependencies; every other file of the block imports this package.
package klc_pkg;

    // Widths fixed by the item fields
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 7;
    localparam int TIME_W  = 48;
    localparam int CODE_W  = 8;
    localparam int PHASE_W = 3;
    localparam int PULSE_W = 16;

    localparam int KEY_COUNT       = 128;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int CMD_SLOTS       = 2;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd28;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_PRESS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELALL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LINE    = 3'd4;

    // Link phase codes
    localparam logic [PHASE_W-1:0] PH_SELFTEST = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_STRM_ON  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_STRM_OFF = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SEND     = 3'd4;

    // Fixed codes
    localparam logic [CODE_W-1:0] CODE_SYNC     = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_STRM_ON  = 8'hFD;
    localparam logic [CODE_W-1:0] CODE_STRM_OFF = 8'hFE;

    // Keys of the reset combination
    localparam logic [KEY_W-1:0] KEY_COMBO_CTRL  = 7'h63;
    localparam logic [KEY_W-1:0] KEY_COMBO_LEFT  = 7'h66;
    localparam logic [KEY_W-1:0] KEY_COMBO_RIGHT = 7'h67;

    // Classified command operations
    typedef enum logic [2:0] {
        OP_PRESS,
        OP_RELEASE,
        OP_TOGGLE,
        OP_RELALL,
        OP_LINE,
        OP_NOP
    } klc_op_t;

    // One classified command as it waits between the front and back parts
    typedef struct packed {
        klc_op_t             op;
        logic [KEY_W-1:0]    key;
        logic                line_level;
        logic [TIME_W-1:0]   event_time;
    } klc_cmd_t;

endpackage

// ----- design/keyboard_link_controller.sv -----
`timescale 1ns / 1ps
// Top level of the keyboard link controller: front classifier and queue,
// back executor with key bitmap, code queue and link state. Depends on klc_pkg.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------------------
//   in       | in_valid / in_stall       | mode, key, line_level, event_time
//   out      | out_valid / out_stall     | code_valid, line_byte, reset_combo, link_phase
//   cfg      | cfg_valid / cfg_ready     | cfg_data (min_pulse_cycles)
//
// The back part takes one command at a time. A key event or unknown mode goes
// from idle to the emit state, a line level beat through the line state and
// the pop state too when it pops the code queue, whose read port is registered.
// Release all walks the 128-entry key bitmap one key per cycle. A two-entry
// command queue lets the input side keep accepting beats while a result waits on
// out_stall. Reset is asynchronous and active low; the bitmap clears at once.
module keyboard_link_controller #(
    parameter int QUEUE_DEPTH = klc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [klc_pkg::MODE_W-1:0]    mode,
    input  logic [klc_pkg::KEY_W-1:0]     key,
    input  logic                          line_level,
    input  logic [klc_pkg::TIME_W-1:0]    event_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          code_valid,
    output logic [klc_pkg::CODE_W-1:0]    line_byte,
    output logic                          reset_combo,
    output logic [klc_pkg::PHASE_W-1:0]   link_phase,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [klc_pkg::PULSE_W-1:0]   cfg_data
);
    import klc_pkg::*;

    klc_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_pop;
    logic     cfg_we;

    // The register accepts a write on any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    klc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .line_level (line_level),
        .event_time (event_time),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    klc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_valid  (code_valid),
        .line_byte   (line_byte),
        .reset_combo (reset_combo),
        .link_phase  (link_phase)
    );

endmodule

// ----- design/klc_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts input beats, classifies the mode and holds the
// commands in a short queue for the back part. Depends on klc_pkg.
module klc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [klc_pkg::MODE_W-1:0]  mode,
    input  logic [klc_pkg::KEY_W-1:0]   key,
    input  logic                        line_level,
    input  logic [klc_pkg::TIME_W-1:0]  event_time,
    output logic                        cmd_valid,
    output klc_pkg::klc_cmd_t           cmd,
    input  logic                        cmd_pop
);
    import klc_pkg::*;

    localparam int SLOT_W = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;
    localparam int FILL_W = $clog2(CMD_SLOTS + 1);

    klc_cmd_t            slot_reg [CMD_SLOTS];
    logic [SLOT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    klc_cmd_t            new_cmd;
    logic                push;
    logic                pop;

    // Classify the incoming beat
    always_comb
    begin
        new_cmd.key        = key;
        new_cmd.line_level = line_level;
        new_cmd.event_time = event_time;
        case (mode)
            MODE_PRESS:   new_cmd.op = OP_PRESS;
            MODE_RELEASE: new_cmd.op = OP_RELEASE;
            MODE_TOGGLE:  new_cmd.op = OP_TOGGLE;
            MODE_RELALL:  new_cmd.op = OP_RELALL;
            MODE_LINE:    new_cmd.op = OP_LINE;
            default:      new_cmd.op = OP_NOP;
        endcase
    end

    // Queue handshake
    assign in_stall  = (fill_reg == FILL_W'(CMD_SLOTS));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && cmd_valid;

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == SLOT_W'(CMD_SLOTS - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == SLOT_W'(CMD_SLOTS - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Command storage carries no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- design/klc_back.sv -----
`timescale 1ns / 1ps
// Back part: executes classified commands against the key bitmap, the code
// queue and the link state, and drives the result register. Depends on klc_pkg.
module klc_back #(
    parameter int QUEUE_DEPTH = klc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  klc_pkg::klc_cmd_t             cmd,
    output logic                          cmd_pop,
    input  logic                          cfg_we,
    input  logic [klc_pkg::PULSE_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          code_valid,
    output logic [klc_pkg::CODE_W-1:0]    line_byte,
    output logic                          reset_combo,
    output logic [klc_pkg::PHASE_W-1:0]   link_phase
);
    import klc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINE,
        S_POP,
        S_EMIT
    } state_t;

    // Byte on the wire: code rotated left by one bit, then inverted
    function automatic logic [CODE_W-1:0] wire_byte(input logic [CODE_W-1:0] c);
        wire_byte = ~{c[CODE_W-2:0], c[CODE_W-1]};
    endfunction

    // Phase reached by a handshake
    function automatic logic [PHASE_W-1:0] handshake_phase(input logic [PHASE_W-1:0] p);
        case (p)
            PH_SELFTEST: handshake_phase = PH_STRM_ON;
            PH_SYNC:     handshake_phase = PH_STRM_ON;
            PH_STRM_ON:  handshake_phase = PH_STRM_OFF;
            PH_STRM_OFF: handshake_phase = PH_SEND;
            default:     handshake_phase = PH_SEND;
        endcase
    endfunction

    state_t                 state_reg, state_next;
    logic [KEY_COUNT-1:0]   key_down_reg, key_down_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic                   busy_reg, busy_next;
    logic [TIME_W-1:0]      low_time_reg, low_time_next;
    logic [TIME_W-1:0]      high_time_reg, high_time_next;
    logic [PULSE_W-1:0]     min_pulse_reg, min_pulse_next;
    logic [KEY_W-1:0]       walk_idx_reg, walk_idx_next;
    logic                   res_tx_reg, res_tx_next;
    logic [CODE_W-1:0]      res_byte_reg, res_byte_next;
    logic                   res_combo_reg, res_combo_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   code_valid_reg, code_valid_next;
    logic [CODE_W-1:0]      line_byte_reg, line_byte_next;
    logic                   reset_combo_reg, reset_combo_next;
    logic [PHASE_W-1:0]     link_phase_reg, link_phase_next;

    // Code queue memory
    logic [CODE_W-1:0]      queue_mem [QUEUE_DEPTH];
    logic [CODE_W-1:0]      rd_data_reg;
    logic                   mem_we;
    logic [CODE_W-1:0]      mem_wdata;

    // Key event datapath
    logic [KEY_W-1:0]       sel_key;
    logic                   sel_down;
    logic                   room;
    logic                   want_press;
    logic                   want_release;
    logic                   do_press;
    logic                   do_release;
    logic [CODE_W-1:0]      key_code;
    logic                   combo_hit;
    logic                   take_cmd;
    logic                   out_free;

    // Line pulse datapath
    logic [PULSE_W-1:0]     min_pulse_eff;
    logic [TIME_W:0]        pulse_diff;
    logic                   handshake_ok;
    logic [PHASE_W-1:0]     hs_phase;

    assign take_cmd = (state_reg == S_IDLE) && cmd_valid;
    assign cmd_pop  = take_cmd;
    assign out_free = !out_valid_reg || !out_stall;

    // Key selection: the command's key, or the walk index during release all
    assign sel_key  = (state_reg == S_WALK) ? walk_idx_reg : cmd.key;
    assign sel_down = key_down_reg[sel_key];
    assign room     = (count_reg != CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        want_press   = 1'b0;
        want_release = 1'b0;
        if (state_reg == S_WALK)
        begin
            want_release = 1'b1;
        end
        else if (take_cmd)
        begin
            case (cmd.op)
                OP_PRESS:   want_press   = 1'b1;
                OP_RELEASE: want_release = 1'b1;
                OP_TOGGLE:
                begin
                    want_press   = !sel_down;
                    want_release = sel_down;
                end
                default:
                begin
                    want_press   = 1'b0;
                    want_release = 1'b0;
                end
            endcase
        end
    end

    assign do_press   = want_press && !sel_down && room;
    assign do_release = want_release && sel_down && room;
    assign key_code   = {do_release, sel_key};

    // Combination check uses the bitmap as it stands after this press
    assign combo_hit = do_press
        && (key_down_reg[KEY_COMBO_CTRL]  || (sel_key == KEY_COMBO_CTRL))
        && (key_down_reg[KEY_COMBO_LEFT]  || (sel_key == KEY_COMBO_LEFT))
        && (key_down_reg[KEY_COMBO_RIGHT] || (sel_key == KEY_COMBO_RIGHT));

    // Pulse length check: a zero setting acts as a setting of one
    assign min_pulse_eff = (min_pulse_reg == '0) ? PULSE_W'(1) : min_pulse_reg;
    assign pulse_diff    = {1'b0, high_time_reg} - {1'b0, low_time_reg};
    assign handshake_ok  = !pulse_diff[TIME_W]
        && (pulse_diff[TIME_W-1:0] >= {{(TIME_W - PULSE_W){1'b0}}, min_pulse_eff});
    assign hs_phase      = handshake_phase(phase_reg);

    // Control sequencer
    always_comb
    begin
        state_next       = state_reg;
        key_down_next    = key_down_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        phase_next       = phase_reg;
        busy_next        = busy_reg;
        low_time_next    = low_time_reg;
        high_time_next   = high_time_reg;
        min_pulse_next   = min_pulse_reg;
        walk_idx_next    = walk_idx_reg;
        res_tx_next      = res_tx_reg;
        res_byte_next    = res_byte_reg;
        res_combo_next   = res_combo_reg;
        out_valid_next   = out_valid_reg;
        code_valid_next  = code_valid_reg;
        line_byte_next   = line_byte_reg;
        reset_combo_next = reset_combo_reg;
        link_phase_next  = link_phase_reg;
        mem_we           = 1'b0;
        mem_wdata        = key_code;

        if (cfg_we)
        begin
            min_pulse_next = cfg_data;
        end

        // The result register empties when its beat is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Start of a new command clears the gathered result
        if (take_cmd)
        begin
            res_tx_next    = 1'b0;
            res_byte_next  = '0;
            res_combo_next = 1'b0;
        end

        // A press or release: an idle link sends the code at once, else it queues
        if (do_press || do_release)
        begin
            key_down_next[sel_key] = do_press;
            if (!busy_reg)
            begin
                res_tx_next   = 1'b1;
                res_byte_next = wire_byte(key_code);
                phase_next    = PH_SEND;
                busy_next     = 1'b1;
            end
            else
            begin
                mem_we     = 1'b1;
                tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
        if (combo_hit)
        begin
            res_combo_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take_cmd)
                begin
                    case (cmd.op)
                        OP_RELALL:
                        begin
                            walk_idx_next = '0;
                            state_next    = S_WALK;
                        end
                        OP_LINE:
                        begin
                            if (cmd.line_level)
                            begin
                                if (high_time_reg <= low_time_reg)
                                begin
                                    high_time_next = cmd.event_time;
                                end
                            end
                            else if (low_time_reg <= high_time_reg)
                            begin
                                low_time_next = cmd.event_time;
                            end
                            state_next = S_LINE;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                walk_idx_next = walk_idx_reg + 1'b1;
                if (walk_idx_reg == KEY_W'(KEY_COUNT - 1))
                begin
                    state_next = S_EMIT;
                end
            end

            S_LINE:
            begin
                state_next = S_EMIT;
                if (handshake_ok)
                begin
                    phase_next = hs_phase;
                    case (hs_phase)
                        PH_SYNC:
                        begin
                            res_tx_next   = 1'b1;
                            res_byte_next = wire_byte(CODE_SYNC);
                            busy_next     = 1'b1;
                        end
                        PH_STRM_ON:
                        begin
                            res_tx_next   = 1'b1;
                            res_byte_next = wire_byte(CODE_STRM_ON);
                            busy_next     = 1'b1;
                        end
                        PH_STRM_OFF:
                        begin
                            res_tx_next   = 1'b1;
                            res_byte_next = wire_byte(CODE_STRM_OFF);
                            busy_next     = 1'b1;
                        end
                        PH_SEND:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_POP;
                            end
                            else
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            busy_next = 1'b1;
                        end
                    endcase
                end
            end

            // The queue head has been read out into rd_data_reg by now
            S_POP:
            begin
                res_tx_next   = 1'b1;
                res_byte_next = wire_byte(rd_data_reg);
                busy_next     = 1'b1;
                head_next     = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next    = count_reg - 1'b1;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    code_valid_next  = res_tx_reg;
                    line_byte_next   = res_byte_reg;
                    reset_combo_next = res_combo_reg;
                    link_phase_next  = phase_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            key_down_reg    <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            phase_reg       <= PH_SELFTEST;
            busy_reg        <= 1'b1;
            low_time_reg    <= '0;
            high_time_reg   <= '0;
            min_pulse_reg   <= MIN_PULSE_RESET;
            walk_idx_reg    <= '0;
            res_tx_reg      <= 1'b0;
            res_byte_reg    <= '0;
            res_combo_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            code_valid_reg  <= 1'b0;
            line_byte_reg   <= '0;
            reset_combo_reg <= 1'b0;
            link_phase_reg  <= PH_SELFTEST;
        end
        else
        begin
            state_reg       <= state_next;
            key_down_reg    <= key_down_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            phase_reg       <= phase_next;
            busy_reg        <= busy_next;
            low_time_reg    <= low_time_next;
            high_time_reg   <= high_time_next;
            min_pulse_reg   <= min_pulse_next;
            walk_idx_reg    <= walk_idx_next;
            res_tx_reg      <= res_tx_next;
            res_byte_reg    <= res_byte_next;
            res_combo_reg   <= res_combo_next;
            out_valid_reg   <= out_valid_next;
            code_valid_reg  <= code_valid_next;
            line_byte_reg   <= line_byte_next;
            reset_combo_reg <= reset_combo_next;
            link_phase_reg  <= link_phase_next;
        end
    end

    // Queue memory: one write port at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[tail_reg] <= mem_wdata;
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    assign out_valid   = out_valid_reg;
    assign code_valid  = code_valid_reg;
    assign line_byte   = line_byte_reg;
    assign reset_combo = reset_combo_reg;
    assign link_phase  = link_phase_reg;

endmodule

// ----- design/klc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the keyboard link controller, bound to the top level.
// Depends on klc_pkg and keyboard_link_controller.
module klc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          code_valid,
    input logic [klc_pkg::CODE_W-1:0]    line_byte,
    input logic                          reset_combo,
    input logic [klc_pkg::PHASE_W-1:0]   link_phase
);
    import klc_pkg::*;

    // A stalled result beat stays in place unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_valid)
            && $stable(line_byte) && $stable(reset_combo) && $stable(link_phase))
        else $error("result beat changed while stalled");

    // No byte sent means the byte field reads zero
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !code_valid |-> line_byte == '0)
        else $error("line_byte not zero without a sent code");

    // A byte is never sent while the link is still in self-test
    a_no_send_selftest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code_valid |-> link_phase != PH_SELFTEST)
        else $error("byte sent in self-test phase");

    // The sync phase is never entered by this block
    a_no_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> link_phase != PH_SYNC)
        else $error("sync phase reported");

endmodule

bind keyboard_link_controller klc_checker u_klc_checker (.*);

// ----- tb/keyboard_link_controller_checker.sv -----
`timescale 1ns / 1ps
// Checker for the keyboard link controller: watches the input, result and register
// channels, predicts every result from its own copy of the link state and compares.
// Depends on klc_pkg; instantiated beside the block by keyboard_link_controller_tb.
module keyboard_link_controller_checker #(
    parameter int QUEUE_DEPTH = klc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [klc_pkg::MODE_W-1:0]    mode,
    input  logic [klc_pkg::KEY_W-1:0]     key,
    input  logic                          line_level,
    input  logic [klc_pkg::TIME_W-1:0]    event_time,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          code_valid,
    input  logic [klc_pkg::CODE_W-1:0]    line_byte,
    input  logic                          reset_combo,
    input  logic [klc_pkg::PHASE_W-1:0]   link_phase,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [klc_pkg::PULSE_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            byte_count,
    output int                            combo_count
);
    import klc_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                 sent;
        logic [CODE_W-1:0]    host_byte;
        logic                 combo;
        logic [PHASE_W-1:0]   phase_out;
    } link_result_t;

    // Results predicted but not yet seen on the output channel.
    link_result_t expected_results[$];

    // Predicted link state.
    logic [KEY_COUNT-1:0]  keys_held;
    logic [CODE_W-1:0]     type_ahead [QUEUE_DEPTH];
    int unsigned           ta_count;
    int unsigned           ta_head;
    int unsigned           ta_tail;
    logic [PHASE_W-1:0]    link_ph;
    logic                  link_busy;
    logic [TIME_W-1:0]     t_low;
    logic [TIME_W-1:0]     t_high;
    logic [PULSE_W-1:0]    pulse_min;

    // What the beat being predicted produces.
    logic                  step_sent;
    logic [CODE_W-1:0]     step_byte;
    logic                  step_combo;

    task automatic reset_link_model();
        keys_held  = '0;
        ta_count   = 0;
        ta_head    = 0;
        ta_tail    = 0;
        link_ph    = PH_SELFTEST;
        link_busy  = 1'b1;
        t_low      = '0;
        t_high     = '0;
        pulse_min  = MIN_PULSE_RESET;
        expected_results.delete();
    endtask

    // A byte on the line is the code rotated left by one bit, then inverted.
    task automatic transmit_code(input logic [CODE_W-1:0] code);
        step_byte = ~{code[CODE_W-2:0], code[CODE_W-1]};
        step_sent = 1'b1;
        link_busy = 1'b1;
    endtask

    task automatic serve_phase();
        logic [CODE_W-1:0] head_code;
        case (link_ph)
            PH_SELFTEST: link_busy = 1'b1;
            PH_SYNC:     transmit_code(CODE_SYNC);
            PH_STRM_ON:  transmit_code(CODE_STRM_ON);
            PH_STRM_OFF: transmit_code(CODE_STRM_OFF);
            default:
            begin
                if (ta_count > 0) begin
                    head_code = type_ahead[ta_head];
                    ta_head   = (ta_head + 1 >= QUEUE_DEPTH) ? 0 : ta_head + 1;
                    ta_count--;
                    transmit_code(head_code);
                end
                else begin
                    link_busy = 1'b0;
                end
            end
        endcase
    endtask

    task automatic enqueue_code(input logic [CODE_W-1:0] code);
        type_ahead[ta_tail] = code;
        ta_tail = (ta_tail + 1 >= QUEUE_DEPTH) ? 0 : ta_tail + 1;
        ta_count++;
    endtask

    // An idle link sends a fresh code at once and enters the send phase.
    task automatic wake_link();
        if (!link_busy) begin
            link_ph = PH_SEND;
            serve_phase();
        end
    endtask

    task automatic press_key(input logic [KEY_W-1:0] k);
        if (!keys_held[k] && ta_count < QUEUE_DEPTH) begin
            keys_held[k] = 1'b1;
            enqueue_code({1'b0, k});
            wake_link();
            if (keys_held[KEY_COMBO_CTRL] && keys_held[KEY_COMBO_LEFT]
                    && keys_held[KEY_COMBO_RIGHT])
                step_combo = 1'b1;
        end
    endtask

    task automatic release_key(input logic [KEY_W-1:0] k);
        if (keys_held[k] && ta_count < QUEUE_DEPTH) begin
            keys_held[k] = 1'b0;
            enqueue_code({1'b1, k});
            wake_link();
        end
    endtask

    task automatic take_handshake();
        case (link_ph)
            PH_SELFTEST: link_ph = PH_STRM_ON;
            PH_SYNC:     link_ph = PH_STRM_ON;
            PH_STRM_ON:  link_ph = PH_STRM_OFF;
            default:     link_ph = PH_SEND;
        endcase
        serve_phase();
    endtask

    // Each edge time is taken only when it follows the other level; the pulse
    // test is made again on every line beat, repeated levels included.
    task automatic line_change(input logic lvl, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] need;
        need = (pulse_min == '0) ? TIME_W'(1) : TIME_W'(pulse_min);
        if (lvl) begin
            if (t_high <= t_low)
                t_high = t;
        end
        else begin
            if (t_low <= t_high)
                t_low = t;
        end
        if (t_high > t_low && (t_high - t_low) >= need)
            take_handshake();
    endtask

    task automatic predict_link_step(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                     input logic lvl, input logic [TIME_W-1:0] t,
                                     output link_result_t r);
        step_sent  = 1'b0;
        step_byte  = '0;
        step_combo = 1'b0;
        case (m)
            MODE_PRESS:   press_key(k);
            MODE_RELEASE: release_key(k);
            MODE_TOGGLE:
            begin
                if (keys_held[k])
                    release_key(k);
                else
                    press_key(k);
            end
            MODE_RELALL:
            begin
                for (int i = 0; i < KEY_COUNT; i++)
                    release_key(KEY_W'(i));
            end
            MODE_LINE:    line_change(lvl, t);
            default:      ;
        endcase
        r.sent      = step_sent;
        r.host_byte = step_sent ? step_byte : '0;
        r.combo     = step_combo;
        r.phase_out = link_ph;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t ns: result %0d, %s: expected %0h, got %0h",
                     $time, result_count, what, want, got);
    endtask

    // Result beats are checked before the input beat of the same edge is predicted.
    always @(posedge clk) begin
        link_result_t want;
        link_result_t got;
        if (!rst_n) begin
            reset_link_model();
        end
        else begin
            if (out_valid && !out_stall) begin
                result_count++;
                got = {code_valid, line_byte, reset_combo, link_phase};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, 16'(got));
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.sent !== want.sent)
                        report_mismatch("code_valid", 16'(want.sent), 16'(got.sent));
                    if (got.host_byte !== want.host_byte)
                        report_mismatch("line_byte", 16'(want.host_byte),
                                        16'(got.host_byte));
                    if (got.combo !== want.combo)
                        report_mismatch("reset_combo", 16'(want.combo), 16'(got.combo));
                    if (got.phase_out !== want.phase_out)
                        report_mismatch("link_phase", 16'(want.phase_out),
                                        16'(got.phase_out));
                end
            end
            if (cfg_valid && cfg_ready)
                pulse_min = cfg_data;
            if (in_valid && !in_stall) begin
                predict_link_step(mode, key, line_level, event_time, want);
                expected_results.push_back(want);
                if (want.sent)
                    byte_count++;
                if (want.combo)
                    combo_count++;
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/keyboard_link_controller_tb.sv -----
`timescale 1ns / 1ps
// Top of the keyboard link controller testbench: clock, reset, stimulus and verdict.
// Depends on klc_pkg, keyboard_link_controller and keyboard_link_controller_checker.
module keyboard_link_controller_tb;
    import klc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 450;
    localparam int PHASES       = 6;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 160;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [TIME_W-1:0] TIME_TOP         = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode;
    logic [KEY_W-1:0]      key;
    logic                  line_level;
    logic [TIME_W-1:0]     event_time;
    logic                  out_valid;
    logic                  out_stall;
    logic                  code_valid;
    logic [CODE_W-1:0]     line_byte;
    logic                  reset_combo;
    logic [PHASE_W-1:0]    link_phase;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [PULSE_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int byte_count;
    int combo_count;

    int                    items_sent;
    int                    cycle_count;
    int                    settings_used;
    int                    hold_left;
    bit                    steady;
    logic [PULSE_W-1:0]    pulse_setting;
    logic [TIME_W-1:0]     line_clock;

    keyboard_link_controller u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .key         (key),
        .line_level  (line_level),
        .event_time  (event_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_valid  (code_valid),
        .line_byte   (line_byte),
        .reset_combo (reset_combo),
        .link_phase  (link_phase),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    keyboard_link_controller_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .key          (key),
        .line_level   (line_level),
        .event_time   (event_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_valid   (code_valid),
        .line_byte    (line_byte),
        .reset_combo  (reset_combo),
        .link_phase   (link_phase),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .byte_count   (byte_count),
        .combo_count  (combo_count)
    );

    // 50 MHz clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: a long hold-off when asked, otherwise random stalls.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (steady) begin
                out_stall = 1'b0;
            end
            else begin
                out_stall = ($urandom_range(99) < 7);
            end
        end
    end

    // Keys of the reset combination turn up often so that it actually forms.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            case ($urandom_range(2))
                0:       return KEY_COMBO_CTRL;
                1:       return KEY_COMBO_LEFT;
                default: return KEY_COMBO_RIGHT;
            endcase
        end
        if (r < 40)
            return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        if (r < 60)
            return KEY_W'($urandom_range(7));
        return KEY_W'($urandom_range(127));
    endfunction

    function automatic logic [MODE_W-1:0] pick_key_mode();
        case ($urandom_range(2))
            0:       return MODE_PRESS;
            1:       return MODE_RELEASE;
            default: return MODE_TOGGLE;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Low widths around the current minimum, mostly long enough to count.
    function automatic logic [TIME_W-1:0] pulse_width();
        logic [TIME_W-1:0] need;
        need = (pulse_setting == '0) ? TIME_W'(1) : TIME_W'(pulse_setting);
        case ($urandom_range(9))
            0:       return need - 1;
            1:       return need;
            2:       return TIME_W'($urandom_range(pulse_setting));
            default: return need + $urandom_range(60);
        endcase
    endfunction

    // Offer one beat at a falling edge and hold it until it is taken.
    // Each offering cycle is left idle with a small chance.
    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                             input logic lv, input logic [TIME_W-1:0] t);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 7)
            gap++;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        mode       = m;
        key        = k;
        line_level = lv;
        event_time = t;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic key_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k);
        send_beat(m, k, 1'($urandom_range(1)), random_stamp());
    endtask

    task automatic line_beat(input logic lv, input logic [TIME_W-1:0] t);
        send_beat(MODE_LINE, pick_key(), lv, t);
    endtask

    // A well-formed handshake attempt: low edge, then high edge after the given width.
    task automatic pulse(input logic [TIME_W-1:0] width);
        line_beat(1'b0, line_clock);
        line_clock = line_clock + width;
        line_beat(1'b1, line_clock);
        line_clock = line_clock + $urandom_range(300, 1);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic settle();
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_pulse(input logic [PULSE_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid     = 1'b0;
        pulse_setting = value;
        settings_used++;
    endtask

    task automatic random_action();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 40) begin
            key_beat(pick_key_mode(), pick_key());
        end
        else if (r < 72) begin
            pulse(pulse_width());
        end
        else if (r < 78) begin
            // Stray line level, possibly a repeat of the current one.
            line_clock = line_clock + $urandom_range(40);
            line_beat(1'($urandom_range(1)), line_clock);
        end
        else if (r < 81) begin
            key_beat(MODE_RELALL, pick_key());
        end
        else if (r < 84) begin
            key_beat(MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST)), pick_key());
        end
        else if (r < 88) begin
            // Burst of presses with no handshake, enough to fill the type-ahead queue.
            n = $urandom_range(24, 16);
            repeat (n) key_beat(MODE_PRESS, KEY_W'($urandom_range(127)));
        end
        else begin
            // Train of handshakes that takes codes out of the queue.
            n = $urandom_range(6, 2);
            repeat (n) pulse(pulse_width());
        end
    endtask

    initial begin
        int plan [PHASES];
        int phase_end;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_PRESS;
        key           = '0;
        line_level    = 1'b0;
        event_time    = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        steady        = 1'b0;
        pulse_setting = MIN_PULSE_RESET;
        settings_used = 1;
        line_clock    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset pulse minimum.
        key_beat(MODE_PRESS, '0);                // queued during self-test
        key_beat(MODE_SPARE_FIRST, '1);
        key_beat(MODE_SPARE_LAST, '0);
        line_beat(1'b0, '0);                     // low at time zero
        line_beat(1'b1, 48'd10);                 // too short
        line_beat(1'b1, 48'd20);                 // repeated high, still too short
        line_beat(1'b0, 48'd100);
        line_beat(1'b1, 48'd128);                // exactly the minimum: stream on
        line_beat(1'b0, 48'd200);
        line_beat(1'b1, 48'd300);                // stream off
        line_beat(1'b1, 48'd400);                // repeated high counts again: send
        line_beat(1'b1, 48'd410);                // queue empty, link goes idle
        key_beat(MODE_PRESS, '1);                // idle link sends at once
        key_beat(MODE_RELEASE, '1);
        key_beat(MODE_PRESS, KEY_COMBO_CTRL);
        key_beat(MODE_PRESS, KEY_COMBO_LEFT);
        key_beat(MODE_TOGGLE, KEY_COMBO_RIGHT);  // completes the combination
        key_beat(MODE_PRESS, KEY_COMBO_CTRL);    // already down, ignored
        key_beat(MODE_RELEASE, 7'd5);            // already up, ignored
        line_beat(1'b0, 48'd1000);
        line_beat(1'b1, 48'd1027);               // one short of the minimum
        line_beat(1'b0, 48'd1100);
        line_beat(1'b1, 48'd1200);
        key_beat(MODE_RELALL, '0);
        key_beat(MODE_TOGGLE, KEY_COMBO_LEFT);

        // Random part in phases, each under its own pulse minimum.
        line_clock = 48'd2000 + $urandom_range(1 << 20);
        plan = '{MIN_PULSE_RESET, 1, 0, 16'hFFFF,
                 $urandom_range(200, 2), $urandom_range(4000, 29)};
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                set_pulse(PULSE_W'(plan[p]));
            end
            steady = (p == 3);
            if (p == 1 || p == 4)
                hold_left = LONG_HOLD;
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end)
                random_action();
        end
        steady = 1'b0;

        // Line times at the very top of the range.
        line_beat(1'b0, TIME_TOP - 48'd70000);
        line_beat(1'b1, TIME_TOP);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input beats under %0d pulse minimums, with output hold-offs",
                 items_sent, settings_used);
        $display("and a stall-free stretch; %0d results checked, %0d bytes sent, %0d combos.",
                 result_count, byte_count, combo_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/klc_pkg.sv
design/klc_front.sv
design/klc_back.sv
design/keyboard_link_controller.sv
design/klc_checker.sv
tb/keyboard_link_controller_checker.sv
tb/keyboard_link_controller_tb.sv
